// ===== hdl/atr_pkg.sv =====
// Shared constants, types and attribute helpers for the ANSI text terminal renderer.
package atr_pkg;

	localparam int ATR_COLUMNS    = 80;
	localparam int ATR_ROWS       = 25;
	localparam int ATR_MAX_PARAMS = 8;

	localparam int ATR_CELLS_MAX = 256 * 64;
	localparam int ATR_AW_MAX    = $clog2(ATR_CELLS_MAX);
	localparam int ATR_LW_MAX    = $clog2(ATR_CELLS_MAX + 1);
	localparam int ATR_CELL_W    = 16;
	localparam int ATR_IN_W      = 24;
	localparam int ATR_OUT_W     = 40;

	localparam logic [7:0] ATR_DEFAULT_COLOUR = 8'd10;

	localparam logic [7:0] ATR_CH_BS       = 8'h08;
	localparam logic [7:0] ATR_CH_TAB      = 8'h09;
	localparam logic [7:0] ATR_CH_LF       = 8'h0A;
	localparam logic [7:0] ATR_CH_CR       = 8'h0D;
	localparam logic [7:0] ATR_CH_ESC      = 8'h1B;
	localparam logic [7:0] ATR_CH_SPACE    = 8'h20;
	localparam logic [7:0] ATR_CH_DIGIT0   = 8'h30;
	localparam logic [7:0] ATR_CH_DIGIT9   = 8'h39;
	localparam logic [7:0] ATR_CH_SEMI     = 8'h3B;
	localparam logic [7:0] ATR_CH_QUESTION = 8'h3F;
	localparam logic [7:0] ATR_CH_LBRACKET = 8'h5B;
	localparam logic [7:0] ATR_CH_UP       = 8'h41;
	localparam logic [7:0] ATR_CH_DOWN     = 8'h42;
	localparam logic [7:0] ATR_CH_RIGHT    = 8'h43;
	localparam logic [7:0] ATR_CH_LEFT     = 8'h44;
	localparam logic [7:0] ATR_CH_COLUMN   = 8'h47;
	localparam logic [7:0] ATR_CH_HOME     = 8'h48;
	localparam logic [7:0] ATR_CH_HOME_ALT = 8'h66;
	localparam logic [7:0] ATR_CH_ERASE_SCR = 8'h4A;
	localparam logic [7:0] ATR_CH_ERASE_LN = 8'h4B;
	localparam logic [7:0] ATR_CH_REV_INDEX = 8'h4D;
	localparam logic [7:0] ATR_CH_DELETE   = 8'h50;
	localparam logic [7:0] ATR_CH_SGR      = 8'h6D;
	localparam logic [7:0] ATR_CH_SAVE     = 8'h73;
	localparam logic [7:0] ATR_CH_RESTORE  = 8'h75;

	localparam logic [2:0] ATR_ANSI_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

	typedef enum logic [1:0] {
		PH_NORMAL,
		PH_ESC,
		PH_CSI
	} atr_phase_t;

	typedef enum logic [1:0] {
		REG_DEFAULT_COLOUR,
		REG_POST_PROCESS,
		REG_NEWLINE_RETURNS,
		REG_OUTPUT_STOPPED
	} atr_reg_t;

	// One memory sweep: an optional cell copy followed by an optional fill.
	typedef struct packed {
		logic [ATR_LW_MAX-1:0] copy_len;
		logic [ATR_AW_MAX-1:0] copy_src;
		logic [ATR_AW_MAX-1:0] copy_dst;
		logic                  copy_down;
		logic [ATR_AW_MAX-1:0] fill_addr;
		logic [ATR_LW_MAX-1:0] fill_len;
		logic [ATR_CELL_W-1:0] fill_word;
	} atr_sweep_cmd_t;

	function automatic logic [7:0] atr_sgr(input logic [15:0] v, input logic [7:0] c,
			input logic [7:0] dflt);
		logic [7:0] r;
		logic [2:0] m;
		r = c;
		m = 3'd0;
		priority if (v == 16'd0) begin
			r = dflt;
		end else if (v == 16'd1) begin
			r = c | 8'h08;
		end else if (v == 16'd2 || v == 16'd22) begin
			r = c & 8'hF7;
		end else if (v == 16'd5 || v == 16'd6) begin
			r = c | 8'h80;
		end else if (v == 16'd7) begin
			r = {c[7], c[2:0], c[3], c[6:4]};
		end else if (v == 16'd39) begin
			r = {c[7:4], dflt[3:0]};
		end else if (v == 16'd49) begin
			r = {dflt[7:4], c[3:0]};
		end else if (v >= 16'd30 && v <= 16'd37) begin
			m = ATR_ANSI_MAP[3'(v - 16'd30)];
			r = {c[7:3], m};
		end else if (v >= 16'd90 && v <= 16'd97) begin
			m = ATR_ANSI_MAP[3'(v - 16'd90)];
			r = {c[7:4], 1'b1, m};
		end else if (v >= 16'd40 && v <= 16'd47) begin
			m = ATR_ANSI_MAP[3'(v - 16'd40)];
			r = {c[7], m, c[3:0]};
		end else if (v >= 16'd100 && v <= 16'd107) begin
			m = ATR_ANSI_MAP[3'(v - 16'd100)];
			r = {1'b1, m, c[3:0]};
		end else begin
			r = c;
		end
		return r;
	endfunction

endpackage

// ===== hdl/atr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module atr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hdl/atr_sweep.sv =====
// Screen sweep engine: pipelined cell copy then fill, one cell per cycle.
module atr_sweep import atr_pkg::*; #(
	parameter int CELLS = ATR_COLUMNS * ATR_ROWS,
	localparam int AW = $clog2(CELLS),
	localparam int LW = $clog2(CELLS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  atr_sweep_cmd_t        cmd,
	output logic                  done,
	output logic [AW-1:0]         rd_addr,
	input  logic [ATR_CELL_W-1:0] rd_data,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output logic [ATR_CELL_W-1:0] wr_data
);

	typedef enum logic [1:0] {
		E_IDLE,
		E_COPY,
		E_FILL
	} eng_state_t;

	eng_state_t            st_q;
	logic                  rdv_s1;
	logic                  done_q;
	logic [AW-1:0]         src_q;
	logic [AW-1:0]         dst_q;
	logic [AW-1:0]         fill_q;
	logic [LW-1:0]         rd_left_q;
	logic [LW-1:0]         wr_left_q;
	logic [LW-1:0]         fill_left_q;
	logic                  down_q;
	logic [ATR_CELL_W-1:0] word_q;

	assign done    = done_q;
	assign rd_addr = src_q;
	assign wr_en   = (st_q == E_COPY && rdv_s1) || st_q == E_FILL;
	assign wr_addr = (st_q == E_FILL) ? fill_q : dst_q;
	assign wr_data = (st_q == E_FILL) ? word_q : rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= E_IDLE;
			rdv_s1      <= 1'b0;
			done_q      <= 1'b0;
			src_q       <= '0;
			dst_q       <= '0;
			fill_q      <= '0;
			rd_left_q   <= '0;
			wr_left_q   <= '0;
			fill_left_q <= '0;
			down_q      <= 1'b0;
			word_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				E_IDLE: begin
					rdv_s1 <= 1'b0;
					if (start) begin
						src_q       <= AW'(cmd.copy_src);
						dst_q       <= AW'(cmd.copy_dst);
						rd_left_q   <= LW'(cmd.copy_len);
						wr_left_q   <= LW'(cmd.copy_len);
						down_q      <= cmd.copy_down;
						fill_q      <= AW'(cmd.fill_addr);
						fill_left_q <= LW'(cmd.fill_len);
						word_q      <= cmd.fill_word;
						if (LW'(cmd.copy_len) != '0) begin
							st_q <= E_COPY;
						end else if (LW'(cmd.fill_len) != '0) begin
							st_q <= E_FILL;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				E_COPY: begin
					// issue reads ahead, write each one in the cycle after its read
					rdv_s1 <= (rd_left_q != '0);
					if (rd_left_q != '0) begin
						src_q     <= down_q ? src_q - AW'(1) : src_q + AW'(1);
						rd_left_q <= rd_left_q - LW'(1);
					end
					if (rdv_s1) begin
						dst_q     <= down_q ? dst_q - AW'(1) : dst_q + AW'(1);
						wr_left_q <= wr_left_q - LW'(1);
						if (wr_left_q == LW'(1)) begin
							if (fill_left_q != '0) begin
								st_q <= E_FILL;
							end else begin
								st_q   <= E_IDLE;
								done_q <= 1'b1;
							end
						end
					end
				end
				E_FILL: begin
					fill_q      <= fill_q + AW'(1);
					fill_left_q <= fill_left_q - LW'(1);
					if (fill_left_q == LW'(1)) begin
						st_q   <= E_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/ansi_text_terminal_renderer.sv =====
// Top level of the ANSI text terminal renderer: byte interpreter, cursor and screen store.
//
// Each input transfer either puts one byte into the terminal (tuser 0) or reads one screen
// cell (tuser 1), and yields exactly one output transfer with the cell and the cursor,
// colour and escape state after the item. After reset the block clears the screen store
// before the first transfer is accepted. A tab writes blank cells up to the next tab stop.
// Erase, line erase and delete-character sweep the screen memory one cell per cycle through
// its single write port; a scroll, or a reverse index on the top row, rewrites every cell.
// SGR applies its parameters one at a time, oldest first. Configuration registers:
// 0x0 default colour, 0x4 line feed enable, 0x8 line feed returns, 0xC output stopped.
module ansi_text_terminal_renderer import atr_pkg::*; #(
	parameter int COLUMNS    = ATR_COLUMNS,
	parameter int ROWS       = ATR_ROWS,
	parameter int MAX_PARAMS = ATR_MAX_PARAMS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [ATR_IN_W-1:0]  s_axis_tdata,  // char_byte[7:0], cell_index[18:8]
	input  logic                 s_axis_tuser,  // opcode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [ATR_OUT_W-1:0] m_axis_tdata,  // cell_char, cell_colour, cursor_row,
	                                            // cursor_col, current_colour, escape_phase
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int LW    = $clog2(CELLS + 1);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int PCW   = $clog2(MAX_PARAMS + 1);
	localparam int PIW   = $clog2(MAX_PARAMS);

	typedef enum logic [2:0] {
		S_INIT,
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SWEEP,
		S_SGR,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic                   op_q;
	logic [7:0]             ch_q;
	logic [10:0]            idx_q;
	logic [7:0]             def_colour_q;
	logic                   opost_q;
	logic                   onlcr_q;
	logic                   stopped_q;
	logic [RW-1:0]          row_q, srow_q;
	logic [CW-1:0]          col_q, scol_q;
	logic [7:0]             colour_q, scolour_q;
	atr_phase_t             phase_q;
	logic [PCW-1:0]         pcount_q;
	logic [15:0]            params_q [MAX_PARAMS];
	logic                   scroll_pend_q;
	logic [PCW-1:0]         sgr_left_q;
	logic [ATR_CELL_W-1:0]  cell_q;
	logic                   out_valid_q;
	logic [ATR_OUT_W-1:0]   out_data_q;

	// next-state values of one executed item
	logic [RW-1:0]          row_d, srow_d;
	logic [CW-1:0]          col_d, scol_d;
	logic [7:0]             colour_d, scolour_d;
	atr_phase_t             phase_d;
	logic [PCW-1:0]         pcount_d, sgr_cnt_d;
	logic [15:0]            params_d [MAX_PARAMS];
	logic                   start_d, scroll_d, sgr_d, rd_req;
	atr_sweep_cmd_t         cmd_d, scroll_cmd, eng_cmd;
	logic                   eng_start, eng_done;

	logic [AW-1:0]          pos, base;
	logic [15:0]            p0, p1, pv, hv;
	logic [16:0]            sum_v;
	logic [PCW-1:0]         c1;
	logic [PIW-1:0]         pidx;
	logic [15:0]            pold;
	logic [CW:0]            room, pn, tn, troom, tcnt;

	logic [AW-1:0]          ram_rd_addr, eng_rd_addr, ram_wr_addr;
	logic                   ram_wr_en;
	logic [ATR_CELL_W-1:0]  ram_rd_data, ram_wr_data;

	logic                   cfg_wr;
	atr_reg_t               cfg_reg;

	assign pready        = 1'b1;
	assign cfg_reg       = atr_reg_t'(paddr[3:2]);
	assign cfg_wr        = psel && penable && pwrite;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		unique case (cfg_reg)
			REG_DEFAULT_COLOUR:  prdata = 32'(def_colour_q);
			REG_POST_PROCESS:    prdata = 32'(opost_q);
			REG_NEWLINE_RETURNS: prdata = 32'(onlcr_q);
			REG_OUTPUT_STOPPED:  prdata = 32'(stopped_q);
			default:             prdata = '0;
		endcase
	end

	assign base = AW'(row_q * COLUMNS);
	assign pos  = base + AW'(col_q);
	assign p0   = params_q[0];
	assign p1   = params_q[1];

	always_comb begin
		scroll_cmd           = '0;
		scroll_cmd.copy_len  = ATR_LW_MAX'(CELLS - COLUMNS);
		scroll_cmd.copy_src  = ATR_AW_MAX'(COLUMNS);
		scroll_cmd.copy_dst  = '0;
		scroll_cmd.copy_down = 1'b0;
		scroll_cmd.fill_addr = ATR_AW_MAX'(CELLS - COLUMNS);
		scroll_cmd.fill_len  = ATR_LW_MAX'(COLUMNS);
		scroll_cmd.fill_word = {colour_q, ATR_CH_SPACE};
	end

	always_comb begin
		row_d     = row_q;
		col_d     = col_q;
		srow_d    = srow_q;
		scol_d    = scol_q;
		colour_d  = colour_q;
		scolour_d = scolour_q;
		phase_d   = phase_q;
		pcount_d  = pcount_q;
		params_d  = params_q;
		sgr_cnt_d = (pcount_q == '0) ? PCW'(1) : pcount_q;
		start_d   = 1'b0;
		scroll_d  = 1'b0;
		sgr_d     = 1'b0;
		rd_req    = 1'b0;
		cmd_d     = '0;
		cmd_d.fill_word = {colour_q, ATR_CH_SPACE};
		pv    = (p0 == 16'd0) ? 16'd1 : p0;
		hv    = (p0 == 16'd0) ? 16'd0 : p0 - 16'd1;
		sum_v = '0;
		c1    = (pcount_q == '0) ? PCW'(1) : pcount_q;
		pidx  = PIW'(c1 - PCW'(1));
		pold  = params_q[pidx];
		room  = (CW+1)'(COLUMNS) - (CW+1)'(col_q);
		pn    = (pv < 16'(room)) ? (CW+1)'(pv) : room;
		tn    = (CW+1)'(8) - (CW+1)'(col_q[2:0]);
		troom = (CW+1)'(COLUMNS - 1) - (CW+1)'(col_q);
		tcnt  = (tn < troom) ? tn : troom;

		if (op_q) begin
			rd_req = (32'(idx_q) < CELLS);
		end else if (ch_q != 8'h00 && !stopped_q) begin
			unique case (phase_q)
				PH_ESC: begin
					phase_d = PH_NORMAL;
					if (ch_q == ATR_CH_LBRACKET) begin
						phase_d  = PH_CSI;
						pcount_d = '0;
						for (int i = 0; i < MAX_PARAMS; i++) begin
							params_d[i] = '0;
						end
					end else if (ch_q == ATR_CH_REV_INDEX) begin
						if (row_q != '0) begin
							row_d = row_q - RW'(1);
						end else begin
							// scroll down: copy from the end toward the top
							start_d         = 1'b1;
							cmd_d.copy_len  = ATR_LW_MAX'(CELLS - COLUMNS);
							cmd_d.copy_src  = ATR_AW_MAX'(CELLS - 1 - COLUMNS);
							cmd_d.copy_dst  = ATR_AW_MAX'(CELLS - 1);
							cmd_d.copy_down = 1'b1;
							cmd_d.fill_addr = '0;
							cmd_d.fill_len  = ATR_LW_MAX'(COLUMNS);
						end
					end
				end
				PH_CSI: begin
					if (ch_q == ATR_CH_QUESTION) begin
						phase_d = PH_CSI;
					end else if (ch_q >= ATR_CH_DIGIT0 && ch_q <= ATR_CH_DIGIT9) begin
						pcount_d       = c1;
						params_d[pidx] = (pold << 3) + (pold << 1) + 16'(ch_q - ATR_CH_DIGIT0);
					end else if (ch_q == ATR_CH_SEMI) begin
						pcount_d = (32'(c1) < MAX_PARAMS) ? c1 + PCW'(1) : c1;
					end else begin
						phase_d = PH_NORMAL;
						unique case (ch_q)
							ATR_CH_UP: begin
								row_d = (16'(row_q) >= pv) ? row_q - RW'(pv) : '0;
							end
							ATR_CH_DOWN: begin
								sum_v = 17'(row_q) + 17'(pv);
								row_d = (sum_v >= 17'(ROWS)) ? RW'(ROWS - 1) : RW'(sum_v);
							end
							ATR_CH_RIGHT: begin
								sum_v = 17'(col_q) + 17'(pv);
								col_d = (sum_v >= 17'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(sum_v);
							end
							ATR_CH_LEFT: begin
								col_d = (16'(col_q) >= pv) ? col_q - CW'(pv) : '0;
							end
							ATR_CH_COLUMN: begin
								col_d = (hv >= 16'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(hv);
							end
							ATR_CH_HOME, ATR_CH_HOME_ALT: begin
								row_d = (hv >= 16'(ROWS)) ? RW'(ROWS - 1) : RW'(hv);
								if (p1 == 16'd0) begin
									col_d = '0;
								end else if (p1 - 16'd1 >= 16'(COLUMNS)) begin
									col_d = CW'(COLUMNS - 1);
								end else begin
									col_d = CW'(p1 - 16'd1);
								end
							end
							ATR_CH_ERASE_SCR: begin
								if (p0 == 16'd0) begin
									start_d         = 1'b1;
									cmd_d.fill_addr = ATR_AW_MAX'(pos);
									cmd_d.fill_len  = ATR_LW_MAX'(LW'(CELLS) - LW'(pos));
								end else if (p0 == 16'd1) begin
									start_d         = 1'b1;
									cmd_d.fill_len  = ATR_LW_MAX'(LW'(pos) + LW'(1));
								end else if (p0 == 16'd2 || p0 == 16'd3) begin
									start_d         = 1'b1;
									cmd_d.fill_len  = ATR_LW_MAX'(CELLS);
									row_d           = '0;
									col_d           = '0;
								end
							end
							ATR_CH_ERASE_LN: begin
								if (p0 == 16'd0) begin
									start_d         = 1'b1;
									cmd_d.fill_addr = ATR_AW_MAX'(pos);
									cmd_d.fill_len  = ATR_LW_MAX'(room);
								end else if (p0 == 16'd1) begin
									start_d         = 1'b1;
									cmd_d.fill_addr = ATR_AW_MAX'(base);
									cmd_d.fill_len  = ATR_LW_MAX'((CW+1)'(col_q) + (CW+1)'(1));
								end else if (p0 == 16'd2) begin
									start_d         = 1'b1;
									cmd_d.fill_addr = ATR_AW_MAX'(base);
									cmd_d.fill_len  = ATR_LW_MAX'(COLUMNS);
								end
							end
							ATR_CH_DELETE: begin
								// shift the row tail left, then blank the freed cells
								start_d         = 1'b1;
								cmd_d.copy_len  = ATR_LW_MAX'(room - pn);
								cmd_d.copy_src  = ATR_AW_MAX'(pos + AW'(pn));
								cmd_d.copy_dst  = ATR_AW_MAX'(pos);
								cmd_d.fill_addr = ATR_AW_MAX'(base + AW'(COLUMNS) - AW'(pn));
								cmd_d.fill_len  = ATR_LW_MAX'(pn);
							end
							ATR_CH_SGR: begin
								sgr_d = 1'b1;
							end
							ATR_CH_SAVE: begin
								srow_d    = row_q;
								scol_d    = col_q;
								scolour_d = colour_q;
							end
							ATR_CH_RESTORE: begin
								colour_d = scolour_q;
								row_d    = srow_q;
								col_d    = scol_q;
							end
							default: begin
								phase_d = PH_NORMAL;
							end
						endcase
					end
				end
				PH_NORMAL: begin
					if (ch_q == ATR_CH_ESC) begin
						phase_d = PH_ESC;
					end else if (ch_q == ATR_CH_CR) begin
						col_d = '0;
					end else if (ch_q == ATR_CH_LF) begin
						if (opost_q) begin
							if (onlcr_q) begin
								col_d = '0;
							end
							if (row_q == RW'(ROWS - 1)) begin
								scroll_d = 1'b1;
							end else begin
								row_d = row_q + RW'(1);
							end
						end
					end else if (ch_q == ATR_CH_BS) begin
						if (col_q != '0) begin
							col_d = col_q - CW'(1);
						end else if (row_q != '0) begin
							row_d = row_q - RW'(1);
							col_d = CW'(COLUMNS - 1);
						end
					end else if (ch_q == ATR_CH_TAB) begin
						start_d         = 1'b1;
						cmd_d.fill_addr = ATR_AW_MAX'(pos);
						cmd_d.fill_len  = ATR_LW_MAX'(tcnt);
						col_d           = CW'((CW+1)'(col_q) + tcnt);
					end else if (ch_q >= ATR_CH_SPACE) begin
						start_d         = 1'b1;
						cmd_d.fill_addr = ATR_AW_MAX'(pos);
						cmd_d.fill_len  = ATR_LW_MAX'(1);
						cmd_d.fill_word = {colour_q, ch_q};
						if (col_q == CW'(COLUMNS - 1)) begin
							col_d = '0;
							if (row_q == RW'(ROWS - 1)) begin
								scroll_d = 1'b1;
							end else begin
								row_d = row_q + RW'(1);
							end
						end else begin
							col_d = col_q + CW'(1);
						end
					end
				end
				default: phase_d = PH_NORMAL;
			endcase
		end
	end

	always_comb begin
		eng_start = 1'b0;
		eng_cmd   = scroll_cmd;
		if (state_q == S_INIT) begin
			eng_start         = 1'b1;
			eng_cmd           = '0;
			eng_cmd.fill_len  = ATR_LW_MAX'(CELLS);
			eng_cmd.fill_word = {colour_q, ATR_CH_SPACE};
		end else if (state_q == S_EXEC) begin
			eng_start = start_d || scroll_d;
			eng_cmd   = start_d ? cmd_d : scroll_cmd;
		end else if (state_q == S_SWEEP) begin
			eng_start = eng_done && scroll_pend_q;
		end
	end

	assign ram_rd_addr = (state_q == S_EXEC) ? AW'(idx_q) : eng_rd_addr;

	atr_ram #(
		.WIDTH(ATR_CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	atr_sweep #(
		.CELLS(CELLS)
	) u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eng_start),
		.cmd    (eng_cmd),
		.done   (eng_done),
		.rd_addr(eng_rd_addr),
		.rd_data(ram_rd_data),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			op_q          <= 1'b0;
			ch_q          <= '0;
			idx_q         <= '0;
			def_colour_q  <= ATR_DEFAULT_COLOUR;
			opost_q       <= 1'b1;
			onlcr_q       <= 1'b1;
			stopped_q     <= 1'b0;
			row_q         <= '0;
			col_q         <= '0;
			srow_q        <= '0;
			scol_q        <= '0;
			colour_q      <= ATR_DEFAULT_COLOUR;
			scolour_q     <= ATR_DEFAULT_COLOUR;
			phase_q       <= PH_NORMAL;
			pcount_q      <= '0;
			for (int i = 0; i < MAX_PARAMS; i++) begin
				params_q[i] <= '0;
			end
			scroll_pend_q <= 1'b0;
			sgr_left_q    <= '0;
			cell_q        <= '0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_reg)
					REG_DEFAULT_COLOUR:  def_colour_q <= pwdata[7:0];
					REG_POST_PROCESS:    opost_q      <= pwdata[0];
					REG_NEWLINE_RETURNS: onlcr_q      <= pwdata[0];
					REG_OUTPUT_STOPPED:  stopped_q    <= pwdata[0];
					default:             stopped_q    <= stopped_q;
				endcase
			end
			if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_INIT: begin
					state_q <= S_CLEAR;
				end
				S_CLEAR: begin
					if (eng_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= s_axis_tuser;
						ch_q    <= s_axis_tdata[7:0];
						idx_q   <= s_axis_tdata[18:8];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					begin
						row_q     <= row_d;
						col_q     <= col_d;
						srow_q    <= srow_d;
						scol_q    <= scol_d;
						colour_q  <= colour_d;
						scolour_q <= scolour_d;
						phase_q   <= phase_d;
						pcount_q  <= pcount_d;
						params_q  <= params_d;
					end
					cell_q        <= '0;
					scroll_pend_q <= start_d && scroll_d;
					sgr_left_q    <= sgr_cnt_d;
					if (rd_req) begin
						state_q <= S_READ;
					end else if (start_d || scroll_d) begin
						state_q <= S_SWEEP;
					end else if (sgr_d) begin
						state_q <= S_SGR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					cell_q  <= ram_rd_data;
					state_q <= S_DONE;
				end
				S_SWEEP: begin
					if (eng_done) begin
						if (scroll_pend_q) begin
							scroll_pend_q <= 1'b0;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SGR: begin
					// apply the oldest parameter and shift the rest down
					colour_q <= atr_sgr(params_q[0], colour_q, def_colour_q);
					for (int i = 0; i < MAX_PARAMS - 1; i++) begin
						params_q[i] <= params_q[i+1];
					end
					sgr_left_q <= sgr_left_q - PCW'(1);
					if (sgr_left_q == PCW'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {2'b00, 2'(phase_q), colour_q, 7'(col_q), 5'(row_q),
							cell_q[15:8], cell_q[7:0]};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
